// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the scheduler unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define SRTF_ASSERT(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

`define SRTF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`else

`define SRTF_ASSERT(lbl, clk, rstn, cond, msg)

`define SRTF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/srtf_pkg.sv -----
package srtf_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int REM_W     = 16;
    localparam int TIME_W    = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_IDLE     = 3'd2,
        ST_RAN      = 3'd3,
        ST_FINISHED = 3'd4
    } t_status;

    // One task slot as it is kept in the slot memory.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [TIME_W-1:0] waited;
        logic [REM_W-1:0]  burst;
        logic [TIME_W-1:0] arrived;
    } t_entry;

endpackage

// ----- rtl/srtf_cmp_unit.sv -----
module srtf_cmp_unit (
    input  srtf_pkg::t_entry i_cand,
    input  srtf_pkg::t_entry i_best,
    input  logic             i_best_vld,
    output logic             o_take
);
    import srtf_pkg::*;

    logic w_rem_lt;
    logic w_rem_eq;
    logic w_arr_lt;

    assign w_rem_lt = (i_cand.rem < i_best.rem);
    assign w_rem_eq = (i_cand.rem == i_best.rem);
    assign w_arr_lt = (i_cand.arrived < i_best.arrived);

    // Strict compares keep the earlier slot on a full tie, since slots are visited in order.
    assign o_take = !i_best_vld || w_rem_lt || (w_rem_eq && w_arr_lt);

endmodule

// ----- rtl/srtf_process_scheduler_unit.sv -----
// Arrival request: one slot's busy bit is checked per cycle, from slot 0 up, until a free one is found.
// Tick request: one pass over the slot memory (one read port, one compare unit), followed
// by the write back of the served slot.
// One request at a time; busy is high from accept until the result strobe.
// Synchronous active-low reset frees all slots and clears time; the result is shown
// for one cycle on o_valid and the receiver cannot stall it.
module srtf_process_scheduler_unit #(
    parameter int SLOTS = srtf_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [srtf_pkg::REM_W-1:0]  i_burst_len,
    output logic                        o_valid,
    output logic [2:0]                  o_status,
    output logic [2:0]                  o_slot,
    output logic [srtf_pkg::TIME_W-1:0] o_wait_total,
    output logic [srtf_pkg::TIME_W-1:0] o_turnaround,
    output logic [srtf_pkg::TIME_W-1:0] o_finish_time
);
    import srtf_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_SCAN,
        S_DONE
    } t_state;

    t_state               r_state,    n_state;
    logic [REM_W-1:0]     r_burst,    n_burst;
    logic [IDX_W-1:0]     r_idx,      n_idx;
    logic                 r_issue,    n_issue;
    logic                 r_pend,     n_pend;
    logic [IDX_W-1:0]     r_pend_idx, n_pend_idx;
    logic [SLOTS-1:0]     r_busy,     n_busy;
    logic [TIME_W-1:0]    r_now,      n_now;
    t_entry               r_best,     n_best;
    logic [IDX_W-1:0]     r_best_idx, n_best_idx;
    logic                 r_best_vld, n_best_vld;
    logic                 r_valid,    n_valid;
    t_status              r_status,   n_status;
    logic [2:0]           r_slot,     n_slot;
    logic [TIME_W-1:0]    r_wait,     n_wait;
    logic [TIME_W-1:0]    r_turn,     n_turn;
    logic [TIME_W-1:0]    r_fin,      n_fin;

    t_entry               r_mem [SLOTS];
    t_entry               r_rd_data;

    logic                 w_rd_en;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_wr_en;
    logic [IDX_W-1:0]     w_wr_addr;
    t_entry               w_wr_data;

    logic                 w_take;
    logic [TIME_W-1:0]    w_now_inc;
    logic [TIME_W-1:0]    w_wait_inc;
    logic [REM_W-1:0]     w_rem_new;
    logic [TIME_W:0]      w_sum;
    logic [TIME_W-1:0]    w_turn_sat;

    srtf_cmp_unit u_cmp (
        .i_cand     (r_rd_data),
        .i_best     (r_best),
        .i_best_vld (r_best_vld),
        .o_take     (w_take)
    );

    assign w_now_inc  = (r_now == TIME_MAX) ? r_now : r_now + TIME_W'(1);
    assign w_wait_inc = (r_rd_data.waited == TIME_MAX) ? r_rd_data.waited
                                                       : r_rd_data.waited + TIME_W'(1);
    assign w_rem_new  = r_best.rem - REM_W'(1);
    assign w_sum      = {1'b0, r_best.waited} + (TIME_W + 1)'(r_best.burst);
    assign w_turn_sat = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_burst    = r_burst;
        n_idx      = r_idx;
        n_issue    = r_issue;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_busy     = r_busy;
        n_now      = r_now;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_best_vld = r_best_vld;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_slot     = r_slot;
        n_wait     = r_wait;
        n_turn     = r_turn;
        n_fin      = r_fin;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_idx;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_pend_idx;
        w_wr_data  = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_idx = '0;
                    if (!i_req_type) begin
                        n_burst = i_burst_len;
                        n_state = S_FIND;
                    end else begin
                        n_issue    = 1'b1;
                        n_pend     = 1'b0;
                        n_best_vld = 1'b0;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_FIND: begin
                n_wait = '0;
                n_turn = '0;
                n_fin  = '0;
                if (r_burst == '0) begin
                    n_valid  = 1'b1;
                    n_status = ST_REJECTED;
                    n_slot   = '0;
                    n_state  = S_IDLE;
                end else if (!r_busy[r_idx]) begin
                    w_wr_en           = 1'b1;
                    w_wr_addr         = r_idx;
                    w_wr_data.rem     = r_burst;
                    w_wr_data.waited  = '0;
                    w_wr_data.burst   = r_burst;
                    w_wr_data.arrived = r_now;
                    n_busy[r_idx]     = 1'b1;
                    n_valid           = 1'b1;
                    n_status          = ST_ACCEPTED;
                    n_slot            = 3'(r_idx);
                    n_state           = S_IDLE;
                end else if (r_idx == IDX_LAST) begin
                    n_valid  = 1'b1;
                    n_status = ST_REJECTED;
                    n_slot   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_SCAN: begin
                // Read slot idx while slot pend_idx, read in the cycle before, is compared and, if busy,
                // written back with one more waiting tick.
                w_rd_en    = r_issue;
                n_pend     = r_issue;
                n_pend_idx = r_idx;
                if (r_issue) begin
                    if (r_idx == IDX_LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                if (r_pend && r_busy[r_pend_idx]) begin
                    w_wr_en          = 1'b1;
                    w_wr_data.waited = w_wait_inc;
                    if (w_take) begin
                        n_best     = r_rd_data;
                        n_best_idx = r_pend_idx;
                        n_best_vld = 1'b1;
                    end
                end
                if (r_pend && r_pend_idx == IDX_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // The served slot is rewritten from its values before the pass,
                // which undoes the waiting tick given to it during the scan.
                n_now   = w_now_inc;
                n_valid = 1'b1;
                n_state = S_IDLE;
                n_wait  = '0;
                n_turn  = '0;
                n_fin   = '0;
                if (!r_best_vld) begin
                    n_status = ST_IDLE;
                    n_slot   = '0;
                end else begin
                    w_wr_en           = 1'b1;
                    w_wr_addr         = r_best_idx;
                    w_wr_data         = r_best;
                    w_wr_data.rem     = w_rem_new;
                    n_slot            = 3'(r_best_idx);
                    if (w_rem_new == '0) begin
                        w_wr_data.waited     = '0;
                        n_busy[r_best_idx]   = 1'b0;
                        n_status             = ST_FINISHED;
                        n_wait               = r_best.waited;
                        n_turn               = w_turn_sat;
                        n_fin                = w_now_inc;
                    end else begin
                        n_status = ST_RAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= 1'b0;
            r_pend     <= 1'b0;
            r_busy     <= '0;
            r_now      <= '0;
            r_best_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_pend     <= n_pend;
            r_busy     <= n_busy;
            r_now      <= n_now;
            r_best_vld <= n_best_vld;
            r_valid    <= n_valid;
        end
        r_burst    <= n_burst;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_wait     <= n_wait;
        r_turn     <= n_turn;
        r_fin      <= n_fin;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_wait_total  = r_wait;
    assign o_turnaround  = r_turn;
    assign o_finish_time = r_fin;

    `SRTF_ASSERT_IMPL(a_strobe_after_busy, i_clk, i_rst_n, o_valid, $past(busy), "result without a request in progress")

    `SRTF_ASSERT_IMPL(a_zero_unless_finished, i_clk, i_rst_n, o_valid && o_status != ST_FINISHED, o_wait_total == '0 && o_turnaround == '0 && o_finish_time == '0, "statistics on a result that did not finish a task")

    `SRTF_ASSERT_IMPL(a_finish_consistent, i_clk, i_rst_n, o_valid && o_status == ST_FINISHED, o_finish_time == r_now && o_turnaround >= o_wait_total, "finishing statistics disagree with time")

endmodule
